// ----- rtl/core/spct_pkg.sv -----
// Package for the shortest path block with price tie-break.
// Field widths, saturation limit and reset values shared by the interfaces and the core.
// No dependencies.
package spct_pkg;

    localparam int NODE_W        = 6;
    localparam int LEN_W         = 16;
    localparam int SUM_W         = 22;
    localparam int CNT_W         = 7;
    localparam int MAX_NODES_DEF = 64;

    localparam logic [CNT_W-1:0] CNT_RESET = CNT_W'(64);
    localparam logic [SUM_W-1:0] SUM_MAX   = {SUM_W{1'b1}};

    localparam logic KIND_EDGE  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

endpackage

// ----- rtl/core/spct_in_if.sv -----
// Input channel: edge writes and queries, valid/ready handshake.
// Depends on spct_pkg.
interface spct_in_if;
    import spct_pkg::*;

    logic              valid;
    logic              ready;
    logic              kind;
    logic [NODE_W-1:0] edge_from;
    logic [NODE_W-1:0] edge_to;
    logic [LEN_W-1:0]  edge_length;
    logic [LEN_W-1:0]  edge_cost;
    logic [NODE_W-1:0] source_node;
    logic [NODE_W-1:0] target_node;

    modport source (output valid, kind, edge_from, edge_to, edge_length, edge_cost,
                    source_node, target_node, input ready);
    modport sink   (input valid, kind, edge_from, edge_to, edge_length, edge_cost,
                    source_node, target_node, output ready);
endinterface

// ----- rtl/core/spct_out_if.sv -----
// Output channel: one query result word, valid/ready handshake.
// Depends on spct_pkg.
interface spct_out_if;
    import spct_pkg::*;

    logic             valid;
    logic             ready;
    logic             reachable;
    logic [SUM_W-1:0] total_length;
    logic [SUM_W-1:0] total_cost;

    modport source (output valid, reachable, total_length, total_cost, input ready);
    modport sink   (input valid, reachable, total_length, total_cost, output ready);
endinterface

// ----- rtl/core/shortest_path_with_cost_tiebreak_top.sv -----
// Dense-graph shortest path with price tie-break: edge store, node store, search sequencer.
// Depends on spct_pkg, spct_in_if, spct_out_if, spct_ram.
//
//  channel   dir  handshake           word
//  in_ch     in   valid/ready         kind, edge_from/to, edge_length/cost, source/target
//  out_ch    out  valid/ready         reachable, total_length, total_cost
//  cfg       in   cfg_we              cfg_data = node_count
//
// Edge word: both directions written in turn through the one edge RAM write port.
// Query: per round one scan of n nodes, a pick step and one relax pass of n nodes;
//   both passes read through the registered RAM read ports.
// After reset the edge RAM is cleared, one entry a cycle, all 2^(2*clog2(MAX_NODES))
//   entries (4096 by default), with in_ch.ready low.
// A finished result waits in the output register; a new word is taken meanwhile.
module shortest_path_with_cost_tiebreak_top #(
    parameter int MAX_NODES = spct_pkg::MAX_NODES_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    spct_in_if.sink                  in_ch,
    spct_out_if.source               out_ch,
    input  logic                     cfg_we,
    input  logic [spct_pkg::CNT_W-1:0] cfg_data
);
    import spct_pkg::*;

    localparam int NW     = $clog2(MAX_NODES);
    localparam int CW     = $clog2(MAX_NODES + 1);
    localparam int EAW    = 2 * NW;
    localparam int EDEPTH = 1 << EAW;
    localparam int EW     = 1 + 2 * LEN_W;
    localparam int NDW    = 2 * SUM_W;

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_EDGE2 = 4'd2;
    localparam logic [3:0] S_SCAN  = 4'd3;
    localparam logic [3:0] S_PICK  = 4'd4;
    localparam logic [3:0] S_RELAX = 4'd5;
    localparam logic [3:0] S_TREAD = 4'd6;
    localparam logic [3:0] S_TWAIT = 4'd7;
    localparam logic [3:0] S_OUT   = 4'd8;

    logic [3:0]           state_reg, state_next;
    logic [CNT_W-1:0]     node_count_reg;
    logic [EAW-1:0]       clr_reg, clr_next;
    logic [CW-1:0]        n_reg, n_next, n_eff;
    logic [CW-1:0]        idx_reg, idx_next;
    logic                 p_vld_reg, p_vld_next;
    logic [NW-1:0]        p_idx_reg, p_idx_next;
    logic [MAX_NODES-1:0] reached_reg, reached_next;
    logic [MAX_NODES-1:0] settled_reg, settled_next;
    logic                 found_reg, found_next;
    logic [NW-1:0]        m_reg, m_next;
    logic [SUM_W-1:0]     min_len_reg, min_len_next;
    logic [SUM_W-1:0]     min_cost_reg, min_cost_next;
    logic [NW-1:0]        tgt_reg, tgt_next;
    logic                 tgt_ok_reg, tgt_ok_next;
    logic [EAW-1:0]       e2_addr_reg, e2_addr_next;
    logic [EW-1:0]        e2_data_reg, e2_data_next;
    logic                 res_reach_reg, res_reach_next;
    logic [SUM_W-1:0]     res_len_reg, res_len_next;
    logic [SUM_W-1:0]     res_cost_reg, res_cost_next;
    logic                 out_valid_reg, out_valid_next;
    logic                 out_reach_reg, out_reach_next;
    logic [SUM_W-1:0]     out_len_reg, out_len_next;
    logic [SUM_W-1:0]     out_cost_reg, out_cost_next;

    logic                 e_we;
    logic [EAW-1:0]       e_waddr, e_raddr;
    logic [EW-1:0]        e_wdata, e_rdata;
    logic                 n_we;
    logic [NW-1:0]        n_waddr, n_raddr;
    logic [NDW-1:0]       n_wdata, n_rdata;

    logic [SUM_W-1:0]     rd_len, rd_cost, nl, nc;
    logic [SUM_W:0]       sum_l, sum_c;

    spct_ram #(.WIDTH(EW), .DEPTH(EDEPTH)) u_edge_ram (
        .clk(clk), .we(e_we), .waddr(e_waddr), .wdata(e_wdata),
        .raddr(e_raddr), .rdata(e_rdata)
    );

    spct_ram #(.WIDTH(NDW), .DEPTH(MAX_NODES)) u_node_ram (
        .clk(clk), .we(n_we), .waddr(n_waddr), .wdata(n_wdata),
        .raddr(n_raddr), .rdata(n_rdata)
    );

    assign in_ch.ready         = (state_reg == S_IDLE);
    assign out_ch.valid        = out_valid_reg;
    assign out_ch.reachable    = out_reach_reg;
    assign out_ch.total_length = out_len_reg;
    assign out_ch.total_cost   = out_cost_reg;

    assign rd_len  = n_rdata[NDW-1:SUM_W];
    assign rd_cost = n_rdata[SUM_W-1:0];
    assign sum_l   = {1'b0, min_len_reg} + (SUM_W+1)'(e_rdata[EW-2:LEN_W]);
    assign sum_c   = {1'b0, min_cost_reg} + (SUM_W+1)'(e_rdata[LEN_W-1:0]);
    assign nl      = sum_l[SUM_W] ? SUM_MAX : sum_l[SUM_W-1:0];
    assign nc      = sum_c[SUM_W] ? SUM_MAX : sum_c[SUM_W-1:0];

    // clamp node_count into 1 .. MAX_NODES
    always_comb
    begin
        if (node_count_reg == '0)
        begin
            n_eff = CW'(1);
        end
        else if (int'(node_count_reg) > MAX_NODES)
        begin
            n_eff = CW'(MAX_NODES);
        end
        else
        begin
            n_eff = CW'(node_count_reg);
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        n_next         = n_reg;
        idx_next       = idx_reg;
        p_vld_next     = 1'b0;
        p_idx_next     = idx_reg[NW-1:0];
        reached_next   = reached_reg;
        settled_next   = settled_reg;
        found_next     = found_reg;
        m_next         = m_reg;
        min_len_next   = min_len_reg;
        min_cost_next  = min_cost_reg;
        tgt_next       = tgt_reg;
        tgt_ok_next    = tgt_ok_reg;
        e2_addr_next   = e2_addr_reg;
        e2_data_next   = e2_data_reg;
        res_reach_next = res_reach_reg;
        res_len_next   = res_len_reg;
        res_cost_next  = res_cost_reg;
        out_valid_next = out_valid_reg && !out_ch.ready;
        out_reach_next = out_reach_reg;
        out_len_next   = out_len_reg;
        out_cost_next  = out_cost_reg;

        e_we    = 1'b0;
        e_waddr = clr_reg;
        e_wdata = '0;
        e_raddr = {m_reg, idx_reg[NW-1:0]};
        n_we    = 1'b0;
        n_waddr = p_idx_reg;
        n_wdata = '0;
        n_raddr = idx_reg[NW-1:0];

        case (state_reg)
            S_CLEAR:
            begin
                e_we     = 1'b1;
                clr_next = clr_reg + EAW'(1);
                if (clr_reg == {EAW{1'b1}})
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_ch.valid)
                begin
                    if (in_ch.kind == KIND_EDGE)
                    begin
                        if (in_ch.edge_from != in_ch.edge_to &&
                            int'(in_ch.edge_from) < MAX_NODES &&
                            int'(in_ch.edge_to) < MAX_NODES)
                        begin
                            e_we         = 1'b1;
                            e_waddr      = {NW'(in_ch.edge_from), NW'(in_ch.edge_to)};
                            e_wdata      = {1'b1, in_ch.edge_length, in_ch.edge_cost};
                            e2_addr_next = {NW'(in_ch.edge_to), NW'(in_ch.edge_from)};
                            e2_data_next = e_wdata;
                            state_next   = S_EDGE2;
                        end
                    end
                    else
                    begin
                        n_next       = n_eff;
                        reached_next = '0;
                        settled_next = '0;
                        tgt_ok_next  = int'(in_ch.target_node) < int'(n_eff);
                        tgt_next     = NW'(in_ch.target_node);
                        if (int'(in_ch.source_node) < int'(n_eff))
                        begin
                            reached_next[NW'(in_ch.source_node)] = 1'b1;
                            n_we       = 1'b1;
                            n_waddr    = NW'(in_ch.source_node);
                            n_wdata    = '0;
                            idx_next   = '0;
                            found_next = 1'b0;
                            state_next = S_SCAN;
                        end
                        else
                        begin
                            state_next = S_TREAD;
                        end
                    end
                end
            end
            S_EDGE2:
            begin
                e_we       = 1'b1;
                e_waddr    = e2_addr_reg;
                e_wdata    = e2_data_reg;
                state_next = S_IDLE;
            end
            S_SCAN:
            begin
                if (p_vld_reg && reached_reg[p_idx_reg] && !settled_reg[p_idx_reg] &&
                    (!found_reg || rd_len < min_len_reg))
                begin
                    found_next    = 1'b1;
                    m_next        = p_idx_reg;
                    min_len_next  = rd_len;
                    min_cost_next = rd_cost;
                end
                if (idx_reg < n_reg)
                begin
                    p_vld_next = 1'b1;
                    idx_next   = idx_reg + CW'(1);
                end
                else
                begin
                    state_next = S_PICK;
                end
            end
            S_PICK:
            begin
                idx_next = '0;
                if (found_reg)
                begin
                    settled_next[m_reg] = 1'b1;
                    state_next          = S_RELAX;
                end
                else
                begin
                    state_next = S_TREAD;
                end
            end
            S_RELAX:
            begin
                if (p_vld_reg && e_rdata[EW-1])
                begin
                    if (!reached_reg[p_idx_reg] || nl < rd_len)
                    begin
                        reached_next[p_idx_reg] = 1'b1;
                        n_we    = 1'b1;
                        n_wdata = {nl, nc};
                    end
                    else if (nl == rd_len && nc < rd_cost)
                    begin
                        n_we    = 1'b1;
                        n_wdata = {rd_len, nc};
                    end
                end
                if (idx_reg < n_reg)
                begin
                    p_vld_next = 1'b1;
                    idx_next   = idx_reg + CW'(1);
                end
                else
                begin
                    idx_next   = '0;
                    found_next = 1'b0;
                    state_next = S_SCAN;
                end
            end
            S_TREAD:
            begin
                n_raddr = tgt_reg;
                if (tgt_ok_reg && reached_reg[tgt_reg])
                begin
                    state_next = S_TWAIT;
                end
                else
                begin
                    res_reach_next = 1'b0;
                    res_len_next   = '0;
                    res_cost_next  = '0;
                    state_next     = S_OUT;
                end
            end
            S_TWAIT:
            begin
                res_reach_next = 1'b1;
                res_len_next   = rd_len;
                res_cost_next  = rd_cost;
                state_next     = S_OUT;
            end
            S_OUT:
            begin
                if (!out_valid_reg || out_ch.ready)
                begin
                    out_valid_next = 1'b1;
                    out_reach_next = res_reach_reg;
                    out_len_next   = res_len_reg;
                    out_cost_next  = res_cost_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_reg        <= '0;
            node_count_reg <= CNT_RESET;
            p_vld_reg      <= 1'b0;
            reached_reg    <= '0;
            settled_reg    <= '0;
            found_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
            idx_reg        <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            p_vld_reg     <= p_vld_next;
            reached_reg   <= reached_next;
            settled_reg   <= settled_next;
            found_reg     <= found_next;
            out_valid_reg <= out_valid_next;
            idx_reg       <= idx_next;
            if (cfg_we)
            begin
                node_count_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg         <= n_next;
        p_idx_reg     <= p_idx_next;
        m_reg         <= m_next;
        min_len_reg   <= min_len_next;
        min_cost_reg  <= min_cost_next;
        tgt_reg       <= tgt_next;
        tgt_ok_reg    <= tgt_ok_next;
        e2_addr_reg   <= e2_addr_next;
        e2_data_reg   <= e2_data_next;
        res_reach_reg <= res_reach_next;
        res_len_reg   <= res_len_next;
        res_cost_reg  <= res_cost_next;
        out_reach_reg <= out_reach_next;
        out_len_reg   <= out_len_next;
        out_cost_reg  <= out_cost_next;
    end

    // relax write-back never lands on the entry read in the same cycle
    a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
        (n_we && state_reg == S_RELAX) |-> (n_waddr != n_raddr))
        else $error("node store write and read collide during relax");

    // only a reached node can be settled
    a_pick_reached: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PICK && found_reg) |-> reached_reg[m_reg])
        else $error("settling a node that was never reached");

    // a result word is only loaded from the output state
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == S_OUT))
        else $error("result word raised outside output state");

    // no word is taken while the edge store is being cleared
    a_clear_block: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |=> (!$past(in_ch.ready) && !out_valid_reg))
        else $error("activity during edge store clear");
endmodule

// ----- rtl/core/spct_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
module spct_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
